// ----- rtl/point_to_local_frame_query_top_defines.svh -----
// Assertion macros for the point-to-local-frame query block.
`ifndef POINT_TO_LOCAL_FRAME_QUERY_TOP_DEFINES_SVH
`define POINT_TO_LOCAL_FRAME_QUERY_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PTLFQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PTLFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ptlfq_pkg.sv -----
// Shared constants, types and tables for the point-to-local-frame query block.
package ptlfq_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned ATAN_ENTRIES      = 24;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIFF_W  = 33;
  localparam int unsigned ROT_W   = 34;
  localparam int unsigned PROD_W  = 67;
  localparam int unsigned FWD_W   = 36;
  localparam int unsigned VEC_W   = 38;
  localparam int unsigned ANG_W   = 32;

  localparam logic signed [ROT_W-1:0] INV_GAIN = ROT_W'(652032874);

  typedef enum logic [2:0] {
    CFG_POS_X         = 3'd0,
    CFG_POS_Y         = 3'd1,
    CFG_POS_Z         = 3'd2,
    CFG_HEADING       = 3'd3,
    CFG_CONE_HALF_COS = 3'd4
  } cfg_idx_e;

  function automatic logic [ANG_W-1:0] atan_lut(input logic [4:0] idx);
    logic [ANG_W-1:0] val;
    case (idx)
      5'd0:    val = 32'h2000_0000;
      5'd1:    val = 32'h12E4_051E;
      5'd2:    val = 32'h09FB_385B;
      5'd3:    val = 32'h0511_11D4;
      5'd4:    val = 32'h028B_0D43;
      5'd5:    val = 32'h0145_D7E1;
      5'd6:    val = 32'h00A2_F61E;
      5'd7:    val = 32'h0051_7C55;
      5'd8:    val = 32'h0028_BE53;
      5'd9:    val = 32'h0014_5F2F;
      5'd10:   val = 32'h000A_2F98;
      5'd11:   val = 32'h0005_17CC;
      5'd12:   val = 32'h0002_8BE6;
      5'd13:   val = 32'h0001_45F3;
      5'd14:   val = 32'h0000_A2FA;
      5'd15:   val = 32'h0000_517D;
      5'd16:   val = 32'h0000_28BE;
      5'd17:   val = 32'h0000_145F;
      5'd18:   val = 32'h0000_0A30;
      5'd19:   val = 32'h0000_0518;
      5'd20:   val = 32'h0000_028C;
      5'd21:   val = 32'h0000_0146;
      5'd22:   val = 32'h0000_00A3;
      5'd23:   val = 32'h0000_0051;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ----- rtl/ptlfq_cordic_rot.sv -----
// Pipelined rotation CORDIC that turns a binary heading into sine and cosine.
module ptlfq_cordic_rot #(
  parameter int unsigned Stages = ptlfq_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [15:0]                          angle_i,
  output logic signed [ptlfq_pkg::ROT_W-1:0]   cos_o,
  output logic signed [ptlfq_pkg::ROT_W-1:0]   sin_o
);
  import ptlfq_pkg::*;

  localparam int unsigned N = (Stages > ATAN_ENTRIES) ? ATAN_ENTRIES : Stages;

  logic signed [ROT_W-1:0] x_src [N];
  logic signed [ROT_W-1:0] y_src [N];
  logic [ANG_W-1:0]        z_src [N];
  logic                    f_src [N];
  logic signed [ROT_W-1:0] x_d [N];
  logic signed [ROT_W-1:0] y_d [N];
  logic [ANG_W-1:0]        z_d [N];
  logic signed [ROT_W-1:0] x_q [N];
  logic signed [ROT_W-1:0] y_q [N];
  logic [ANG_W-1:0]        z_q [N];
  logic                    flip_q [N];
  logic [ANG_W-1:0]        z_init;
  logic [ANG_W-1:0]        z_test;

  always_comb begin
    z_init = {angle_i, 16'h0000};
    z_test = z_init + 32'h4000_0000;
    for (int s = 0; s < N; s++) begin
      if (s == 0) begin
        x_src[s] = INV_GAIN;
        y_src[s] = '0;
        z_src[s] = z_test[31] ? z_init + 32'h8000_0000 : z_init;
        f_src[s] = z_test[31];
      end else begin
        x_src[s] = x_q[s-1];
        y_src[s] = y_q[s-1];
        z_src[s] = z_q[s-1];
        f_src[s] = flip_q[s-1];
      end
      if (!z_src[s][31]) begin
        x_d[s] = x_src[s] - (y_src[s] >>> s);
        y_d[s] = y_src[s] + (x_src[s] >>> s);
        z_d[s] = z_src[s] - atan_lut(5'(s));
      end else begin
        x_d[s] = x_src[s] + (y_src[s] >>> s);
        y_d[s] = y_src[s] - (x_src[s] >>> s);
        z_d[s] = z_src[s] + atan_lut(5'(s));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      flip_q <= f_src;
      cos_o  <= flip_q[N-1] ? -x_q[N-1] : x_q[N-1];
      sin_o  <= flip_q[N-1] ? -y_q[N-1] : y_q[N-1];
    end
  end

endmodule

// ----- rtl/ptlfq_cordic_vec.sv -----
// Pipelined vectoring CORDIC that gives the angle of a local offset vector.
module ptlfq_cordic_vec #(
  parameter int unsigned Stages = ptlfq_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [ptlfq_pkg::FWD_W-1:0]   x_i,
  input  logic signed [ptlfq_pkg::FWD_W-1:0]   y_i,
  output logic [ptlfq_pkg::ANG_W-1:0]          angle_o
);
  import ptlfq_pkg::*;

  localparam int unsigned N = (Stages > ATAN_ENTRIES) ? ATAN_ENTRIES : Stages;

  logic signed [VEC_W-1:0] x0_q;
  logic signed [VEC_W-1:0] y0_q;
  logic [ANG_W-1:0]        z0_q;
  logic signed [VEC_W-1:0] x_src [N];
  logic signed [VEC_W-1:0] y_src [N];
  logic [ANG_W-1:0]        z_src [N];
  logic signed [VEC_W-1:0] x_d [N];
  logic signed [VEC_W-1:0] y_d [N];
  logic [ANG_W-1:0]        z_d [N];
  logic signed [VEC_W-1:0] x_q [N];
  logic signed [VEC_W-1:0] y_q [N];
  logic [ANG_W-1:0]        z_q [N];
  logic signed [VEC_W-1:0] x_ext;
  logic signed [VEC_W-1:0] y_ext;

  assign x_ext = VEC_W'(x_i);
  assign y_ext = VEC_W'(y_i);

  always_comb begin
    for (int s = 0; s < N; s++) begin
      if (s == 0) begin
        x_src[s] = x0_q;
        y_src[s] = y0_q;
        z_src[s] = z0_q;
      end else begin
        x_src[s] = x_q[s-1];
        y_src[s] = y_q[s-1];
        z_src[s] = z_q[s-1];
      end
      if (y_src[s] > 0) begin
        x_d[s] = x_src[s] + (y_src[s] >>> s);
        y_d[s] = y_src[s] - (x_src[s] >>> s);
        z_d[s] = z_src[s] + atan_lut(5'(s));
      end else begin
        x_d[s] = x_src[s] - (y_src[s] >>> s);
        y_d[s] = y_src[s] + (x_src[s] >>> s);
        z_d[s] = z_src[s] - atan_lut(5'(s));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (x_ext < 0) begin
        x0_q <= -x_ext;
        y0_q <= -y_ext;
        z0_q <= 32'h8000_0000;
      end else begin
        x0_q <= x_ext;
        y0_q <= y_ext;
        z0_q <= '0;
      end
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign angle_o = z_q[N-1];

endmodule

// ----- rtl/point_to_local_frame_query_top.sv -----
// Throughput: one transaction per cycle; the pipeline advances whenever the output
// register is empty or being taken, so a held result stalls every stage together.
// Sine and cosine come from a rotation CORDIC pipeline, the heading from a vectoring one.
// Reset clears the configuration registers to zero and empties the pipeline.
module point_to_local_frame_query_top #(
  parameter int unsigned CORDIC_STAGES = ptlfq_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [2:0]                           cfg_index_i,
  input  logic [31:0]                          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [31:0]                   point_x_i,
  input  logic signed [31:0]                   point_y_i,
  input  logic signed [31:0]                   point_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [31:0]                   local_forward_o,
  output logic signed [31:0]                   local_side_o,
  output logic                                 is_front_o,
  output logic                                 is_left_o,
  output logic                                 is_in_cone_o,
  output logic signed [15:0]                   relative_heading_o
);
  import ptlfq_pkg::*;

  localparam int unsigned N = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
  localparam int unsigned V = 2 * N + 4;

  logic signed [31:0] pos_x_q, pos_y_q, pos_z_q;
  logic [15:0]        heading_q;
  logic signed [15:0] cone_k_q;
  logic [30:0]        k2_q;
  logic signed [31:0] k_sq;

  logic               en;
  logic [V:0]         vld_q;

  logic signed [DIFF_W-1:0] dx_d, dy_d, dz_d;
  logic signed [DIFF_W-1:0] dx_dl_q [N+1];
  logic signed [DIFF_W-1:0] dz_dl_q [N+1];
  logic signed [DIFF_W-1:0] dy_q;
  logic [N+4:0]             zero_dl_q;

  logic signed [31:0] hx, hy, hz;
  logic signed [63:0] sqx, sqy, sqz;
  logic signed [63:0] sqx_q, sqy_q, sqz_q;
  logic [63:0]        l2_dl_q [N+1];

  logic signed [ROT_W-1:0]  cos_w, sin_w;
  logic signed [PROD_W-1:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [PROD_W:0]   fsum, ssum;
  logic signed [FWD_W-1:0]  fwd_q, side_q;

  logic signed [FWD_W-2:0]  hf;
  logic [FWD_W-3:0]         habs_q;
  logic [62:0]              plo_q, phi_q;
  logic                     fpos_q, fpos2_q;
  logic [67:0]              f2_q;
  logic [94:0]              rprod_q;
  logic [97:0]              f2s;
  logic                     cone_d;

  logic signed [31:0] fsat_d, ssat_d;
  logic signed [31:0] fsat_dl_q [N+1];
  logic signed [31:0] ssat_dl_q [N+1];
  logic [N:0]         front_dl_q, left_dl_q;
  logic [N-2:0]       cone_dl_q;

  logic [ANG_W-1:0]   vec_angle;
  logic [ANG_W-1:0]   angle_round;

  assign cfg_ready_o = 1'b1;
  assign en          = !vld_q[V] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[V];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      pos_z_q   <= '0;
      heading_q <= '0;
      cone_k_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_POS_X:         pos_x_q   <= cfg_data_i;
        CFG_POS_Y:         pos_y_q   <= cfg_data_i;
        CFG_POS_Z:         pos_z_q   <= cfg_data_i;
        CFG_HEADING:       heading_q <= cfg_data_i[15:0];
        CFG_CONE_HALF_COS: cone_k_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign k_sq = cone_k_q * cone_k_q;

  always_ff @(posedge clk_i) begin
    k2_q <= k_sq[30:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[V-1:0], in_valid_i};
    end
  end

  assign dx_d = DIFF_W'(point_x_i) - DIFF_W'(pos_x_q);
  assign dy_d = DIFF_W'(point_y_i) - DIFF_W'(pos_y_q);
  assign dz_d = DIFF_W'(point_z_i) - DIFF_W'(pos_z_q);

  assign hx  = 32'(dx_dl_q[0] >>> 1);
  assign hy  = 32'(dy_q >>> 1);
  assign hz  = 32'(dz_dl_q[0] >>> 1);
  assign sqx = hx * hx;
  assign sqy = hy * hy;
  assign sqz = hz * hz;

  ptlfq_cordic_rot #(
    .Stages (N)
  ) u_rot (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (heading_q),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  assign fsum = (PROD_W+1)'(pa_q) + (PROD_W+1)'(pb_q) + (PROD_W+1)'(1 << 29);
  assign ssum = (PROD_W+1)'(pc_q) - (PROD_W+1)'(pd_q) + (PROD_W+1)'(1 << 29);

  assign hf = (FWD_W-1)'(fwd_q >>> 1);

  always_comb begin
    if (fwd_q > (FWD_W)'(32'sh7FFF_FFFF)) begin
      fsat_d = 32'sh7FFF_FFFF;
    end else if (fwd_q < -(FWD_W)'(33'sh0_8000_0000)) begin
      fsat_d = 32'sh8000_0000;
    end else begin
      fsat_d = fwd_q[31:0];
    end
    if (side_q > (FWD_W)'(32'sh7FFF_FFFF)) begin
      ssat_d = 32'sh7FFF_FFFF;
    end else if (side_q < -(FWD_W)'(33'sh0_8000_0000)) begin
      ssat_d = 32'sh8000_0000;
    end else begin
      ssat_d = side_q[31:0];
    end
  end

  assign f2s = {f2_q, 30'b0};

  always_comb begin
    if (zero_dl_q[N+4]) begin
      cone_d = 1'b0;
    end else if (fpos2_q) begin
      cone_d = cone_k_q[15] ? 1'b1 : (98'(rprod_q) < f2s);
    end else begin
      cone_d = cone_k_q[15] ? (f2s < 98'(rprod_q)) : 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_dl_q[0] <= dx_d;
      dz_dl_q[0] <= dz_d;
      dy_q       <= dy_d;
      zero_dl_q  <= {zero_dl_q[N+3:0], (dx_d == '0) && (dy_d == '0) && (dz_d == '0)};
      for (int i = 1; i < N + 1; i++) begin
        dx_dl_q[i] <= dx_dl_q[i-1];
        dz_dl_q[i] <= dz_dl_q[i-1];
        l2_dl_q[i] <= l2_dl_q[i-1];
        fsat_dl_q[i] <= fsat_dl_q[i-1];
        ssat_dl_q[i] <= ssat_dl_q[i-1];
      end
      sqx_q      <= sqx;
      sqy_q      <= sqy;
      sqz_q      <= sqz;
      l2_dl_q[0] <= 64'(sqx_q) + 64'(sqy_q) + 64'(sqz_q);

      pa_q <= sin_w * dx_dl_q[N];
      pb_q <= cos_w * dz_dl_q[N];
      pc_q <= cos_w * dx_dl_q[N];
      pd_q <= sin_w * dz_dl_q[N];

      fwd_q  <= fsum[65:30];
      side_q <= ssum[65:30];

      habs_q <= hf[FWD_W-2] ? (FWD_W-2)'(-hf) : (FWD_W-2)'(hf);
      plo_q  <= 63'(k2_q) * 63'(l2_dl_q[N][31:0]);
      phi_q  <= 63'(k2_q) * 63'(l2_dl_q[N][63:32]);
      fpos_q <= fwd_q > 0;
      fsat_dl_q[0] <= fsat_d;
      ssat_dl_q[0] <= ssat_d;
      front_dl_q   <= {front_dl_q[N-1:0], fwd_q > 0};
      left_dl_q    <= {left_dl_q[N-1:0], side_q > 0};

      f2_q    <= 68'(habs_q) * 68'(habs_q);
      rprod_q <= (95'(phi_q) << 32) + 95'(plo_q);
      fpos2_q <= fpos_q;

      cone_dl_q <= {cone_dl_q[N-3:0], cone_d};

      local_forward_o    <= fsat_dl_q[N];
      local_side_o       <= ssat_dl_q[N];
      is_front_o         <= front_dl_q[N];
      is_left_o          <= left_dl_q[N];
      is_in_cone_o       <= cone_dl_q[N-2];
      relative_heading_o <= angle_round[31:16];
    end
  end

  ptlfq_cordic_vec #(
    .Stages (N)
  ) u_vec (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (fwd_q),
    .y_i     (side_q),
    .angle_o (vec_angle)
  );

  assign angle_round = vec_angle + 32'h0000_8000;

endmodule

// ----- rtl/ptlfq_checker.sv -----
// Port-level checks for the point-to-local-frame query block, bound to the top level.
`include "point_to_local_frame_query_top_defines.svh"

module ptlfq_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_ready_o,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic signed [31:0] local_forward_o,
  input  logic signed [31:0] local_side_o,
  input  logic               is_front_o,
  input  logic               is_left_o
);

  `PTLFQ_ASSERT_NEXT(a_out_valid_holds, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")
  `PTLFQ_ASSERT_NEXT(a_out_payload_holds, out_valid_o && !out_ready_i, $stable(local_forward_o), "payload changed while stalled")
  `PTLFQ_ASSERT_SAME(a_front_matches, out_valid_o, is_front_o == (local_forward_o > 0), "front flag disagrees with forward offset")
  `PTLFQ_ASSERT_SAME(a_left_matches, out_valid_o, is_left_o == (local_side_o > 0), "left flag disagrees with side offset")
  `PTLFQ_ASSERT_SAME(a_stall_cause, !in_ready_o, out_valid_o && !out_ready_i, "input stalled without a held result")

endmodule

bind point_to_local_frame_query_top ptlfq_checker u_ptlfq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .local_forward_o (local_forward_o),
  .local_side_o    (local_side_o),
  .is_front_o      (is_front_o),
  .is_left_o       (is_left_o)
);
